@@ rtl/tpg_pkg.sv @@
`timescale 1ns / 1ps
package tpg_pkg;

    // defaults for the frame size limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // field and register widths
    localparam int PLANE_W  = 2;
    localparam int COORD_W  = 12;
    localparam int SAMPLE_W = 8;
    localparam int MODE_W   = 2;
    localparam int DIM_W    = 13;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

    // register index within the apb window
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // lane widths
    localparam int GN_W    = COORD_W + 8;      // coordinate times 255
    localparam int GQ_W    = 8;                // gradient quotient
    localparam int BAR_N_W = COORD_W + 1;      // 2c+1
    localparam int BAR_Q_W = 3;                // bar index
    localparam int SQ_W    = 2 * COORD_W + 1;  // dx*dx + dy*dy
    localparam int ROOT_W  = 13;               // floor sqrt of SQ_W bits
    localparam int RAD_N_W = ROOT_W + 7;       // root times 127
    localparam int RAD_Q_W = RAD_N_W;          // full quotient for divisor 1

    // pipeline positions
    localparam int SQ_FIRST   = 2;                    // first root cell
    localparam int RAD_INIT   = SQ_FIRST + ROOT_W;    // radial numerator stage
    localparam int NUM_STAGES = RAD_INIT + RAD_Q_W;   // last cell stage
    localparam int PIPE_LAT   = NUM_STAGES + 2;       // accept edge to strobe edge

    typedef enum logic [1:0] {
        MODE_DIAG = 2'd0,
        MODE_BARS = 2'd1,
        MODE_GRAD = 2'd2,
        MODE_OFF  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PLANE_Y    = 2'd0,
        PLANE_U    = 2'd1,
        PLANE_V    = 2'd2,
        PLANE_NONE = 2'd3
    } t_plane;

    typedef struct packed {
        logic                outside;
        t_mode               mode;
        t_plane              plane;
        logic [SAMPLE_W-1:0] simple;
        logic                bar_ok;
        logic                zero_rad;
    } t_side;

    // white, yellow, cyan, green, magenta, red, blue, black as {y, u, v}
    localparam logic [23:0] BAR_YUV [8] = '{
        24'hEB8080, 24'hD21092, 24'hAAA610, 24'h913622,
        24'h6BCADE, 24'h525AF0, 24'h29F06E, 24'h108080
    };

    function automatic logic [SAMPLE_W-1:0] bar_colour(input logic [BAR_Q_W-1:0] bar,
                                                       input t_plane plane);
        logic [23:0] yuv;
        yuv = BAR_YUV[bar];
        case (plane)
            PLANE_Y: return yuv[23:16];
            PLANE_U: return yuv[15:8];
            PLANE_V: return yuv[7:0];
            default: return '0;
        endcase
    endfunction

endpackage

@@ rtl/tpg_div_cell.sv @@
`timescale 1ns / 1ps
// one restoring division step per cell
module tpg_div_cell #(
    parameter int NW  = 20,
    parameter int DW  = 13,
    parameter int QW  = 8,
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_rem,
    input  logic [DW-1:0] i_div,
    input  logic [QW-1:0] i_quo,
    output logic [NW-1:0] o_rem,
    output logic [DW-1:0] o_div,
    output logic [QW-1:0] o_quo
);
    localparam int TW = NW + DW + QW;

    logic [TW-1:0] w_trial;
    logic          w_fit;
    logic [NW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic [NW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [QW-1:0] r_quo;

    always_comb begin
        w_trial    = TW'(i_div) << BIT;
        w_fit      = TW'(i_rem) >= w_trial;
        n_rem      = w_fit ? (i_rem - w_trial[NW-1:0]) : i_rem;
        n_quo      = i_quo;
        n_quo[BIT] = w_fit;
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= i_div;
        r_quo <= n_quo;
    end

    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = r_quo;
endmodule

@@ rtl/tpg_sqrt_cell.sv @@
`timescale 1ns / 1ps
// one bit of a restoring square root per cell, rem holds n - root^2
module tpg_sqrt_cell #(
    parameter int NW  = 25,
    parameter int RW  = 13,
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_rem,
    input  logic [RW-1:0] i_root,
    output logic [NW-1:0] o_rem,
    output logic [RW-1:0] o_root
);
    localparam int TW = NW + 2;

    logic [TW-1:0] w_trial;
    logic          w_fit;
    logic [NW-1:0] n_rem;
    logic [RW-1:0] n_root;
    logic [NW-1:0] r_rem;
    logic [RW-1:0] r_root;

    always_comb begin
        w_trial     = (TW'(i_root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
        w_fit       = TW'(i_rem) >= w_trial;
        n_rem       = w_fit ? (i_rem - w_trial[NW-1:0]) : i_rem;
        n_root      = i_root;
        n_root[BIT] = w_fit;
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

@@ rtl/yuv420_test_pattern_generator.sv @@
`timescale 1ns / 1ps
// yuv420 planar test pattern source, one sample per beat
//
// command channel: start with i_plane/i_col/i_row is taken at any edge where
// busy is low; busy stays low, so a new beat can enter on every clock
// result channel: o_valid marks o_sample/o_outside for exactly one cycle,
// from the output register after the last radial divider cell; the receiver cannot stall, none is needed
// throughput: one sample per clock, set by the chain of cells: every cell
// does one quotient or root bit and passes its beat on each cycle
// chain: accept stage, square stage, 13 root cells, radial numerator stage,
// 20 radial divider cells, output register; gradient and bar dividers run
// in the first cells beside the root
// config: apb window, mode at 0x0, width at 0x4, height at 0x8; write only
// while no beat is in flight
// reset: synchronous, clears all beat valid flags and loads mode diagonal,
// width 640, height 480
module yuv420_test_pattern_generator #(
    parameter int MAX_WIDTH  = tpg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tpg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpg_pkg::APB_AW-1:0]    paddr,
    input  logic [tpg_pkg::APB_DW-1:0]    pwdata,
    output logic [tpg_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [tpg_pkg::PLANE_W-1:0]   i_plane,
    input  logic [tpg_pkg::COORD_W-1:0]   i_col,
    input  logic [tpg_pkg::COORD_W-1:0]   i_row,
    output logic                          o_valid,
    output logic [tpg_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                          o_outside
);
    import tpg_pkg::*;

    // size arithmetic widths follow the frame limits
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int XW   = (WW > DIM_W) ? WW : DIM_W;
    localparam int YW   = (HW > DIM_W) ? HW : DIM_W;
    localparam int BW_W = WW - 3;
    localparam int CX_W = WW - 2;
    localparam int CY_W = HW - 2;
    localparam int MR_W = CX_W;
    localparam int CM_W = (CX_W > CY_W) ? CX_W : CY_W;
    localparam int NS   = NUM_STAGES;

    // ---------------- configuration registers ----------------
    logic [MODE_W-1:0] r_mode;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic              w_wr;
    logic [1:0]        w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_reg  = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_DIAG;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (w_wr) begin
            case (w_reg)
                REG_MODE:   r_mode   <= pwdata[MODE_W-1:0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_MODE:   prdata = APB_DW'(r_mode);
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    // the chain never stalls
    assign busy = 1'b0;

    // ---------------- frame size, saturated ----------------
    logic [XW-1:0] w_wext;
    logic [YW-1:0] w_hext;
    logic [WW-1:0] w_w;
    logic [HW-1:0] w_h;

    always_comb begin
        w_wext = XW'(r_width);
        w_hext = YW'(r_height);
        if (w_wext < XW'(2))              w_w = WW'(2);
        else if (w_wext > XW'(MAX_WIDTH)) w_w = WW'(MAX_WIDTH);
        else                              w_w = w_wext[WW-1:0];
        if (w_hext < YW'(2))               w_h = HW'(2);
        else if (w_hext > YW'(MAX_HEIGHT)) w_h = HW'(MAX_HEIGHT);
        else                               w_h = w_hext[HW-1:0];
    end

    // ---------------- accept stage decode ----------------
    t_plane              w_plane;
    logic [WW-1:0]       w_pw;
    logic [HW-1:0]       w_ph;
    logic [COORD_W:0]    w_diag;
    logic [BAR_N_W-1:0]  w_bar_num;
    logic [BW_W-1:0]     w_bw;
    logic [CX_W-1:0]     w_cx;
    logic [CY_W-1:0]     w_cy;
    logic [CM_W-1:0]     w_min;
    logic [COORD_W-1:0]  w_dx;
    logic [COORD_W-1:0]  w_dy;
    t_side               w_side;

    always_comb begin
        w_plane   = t_plane'(i_plane);
        w_pw      = (w_plane == PLANE_Y) ? w_w : (w_w >> 1);
        w_ph      = (w_plane == PLANE_Y) ? w_h : (w_h >> 1);
        w_diag    = {1'b0, i_col} + {1'b0, i_row};
        w_bar_num = (w_plane == PLANE_Y) ? {1'b0, i_col} : {i_col, 1'b1};
        w_bw      = w_w[WW-1:3];
        w_cx      = w_w[WW-1:2];
        w_cy      = w_h[HW-1:2];
        w_min     = (CM_W'(w_cx) < CM_W'(w_cy)) ? CM_W'(w_cx) : CM_W'(w_cy);
        // distance from the chroma plane center
        if (XW'(i_col) >= XW'(w_cx)) w_dx = COORD_W'(XW'(i_col) - XW'(w_cx));
        else                         w_dx = COORD_W'(XW'(w_cx) - XW'(i_col));
        if (YW'(i_row) >= YW'(w_cy)) w_dy = COORD_W'(YW'(i_row) - YW'(w_cy));
        else                         w_dy = COORD_W'(YW'(w_cy) - YW'(i_row));

        w_side.outside  = (w_plane == PLANE_NONE) || (XW'(i_col) >= XW'(w_pw))
                          || (YW'(i_row) >= YW'(w_ph));
        w_side.mode     = t_mode'(r_mode);
        w_side.plane    = w_plane;
        w_side.bar_ok   = (w_bw != '0) && (XW'(w_bar_num) < XW'({w_bw, 3'b000}));
        w_side.zero_rad = (w_min == '0);
        // diagonal ramp needs no division, and the unused mode gives zero
        case (t_mode'(r_mode))
            MODE_DIAG: w_side.simple = (w_plane == PLANE_Y) ? w_diag[SAMPLE_W:1]
                                                            : SAMPLE_W'(128);
            default:   w_side.simple = '0;
        endcase
    end

    // ---------------- beat sideband along the chain ----------------
    t_side r_side [0:NS];
    logic  r_vld  [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld[0] <= 1'b0;
        else          r_vld[0] <= start & ~busy;
        r_side[0] <= w_side;
    end

    for (genvar k = 1; k <= NS; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k] <= 1'b0;
            else          r_vld[k] <= r_vld[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    // ---------------- lanes ----------------
    // luma gradient: col*255/w and row*255/h, one quotient bit per cell
    logic [GN_W-1:0]    gx_rem [0:NS];
    logic [WW-1:0]      gx_div [0:NS];
    logic [GQ_W-1:0]    gx_quo [0:NS];
    logic [GN_W-1:0]    gy_rem [0:NS];
    logic [HW-1:0]      gy_div [0:NS];
    logic [GQ_W-1:0]    gy_quo [0:NS];
    // color bar index
    logic [BAR_N_W-1:0] br_rem [0:NS];
    logic [BW_W-1:0]    br_div [0:NS];
    logic [BAR_Q_W-1:0] br_quo [0:NS];
    // radial chroma: distance, root, then root*127 over the radius limit
    logic [COORD_W-1:0] r_dx;
    logic [COORD_W-1:0] r_dy;
    logic [MR_W-1:0]    mr     [0:RAD_INIT-1];
    logic [SQ_W-1:0]    sq_rem [1:RAD_INIT-1];
    logic [ROOT_W-1:0]  sq_rt  [1:RAD_INIT-1];
    logic [RAD_N_W-1:0] rd_rem [RAD_INIT:NS];
    logic [MR_W-1:0]    rd_div [RAD_INIT:NS];
    logic [RAD_Q_W-1:0] rd_quo [RAD_INIT:NS];

    always_ff @(posedge i_clk) begin
        gx_rem[0] <= (GN_W'(i_col) << 8) - GN_W'(i_col);
        gx_div[0] <= w_w;
        gx_quo[0] <= '0;
        gy_rem[0] <= (GN_W'(i_row) << 8) - GN_W'(i_row);
        gy_div[0] <= w_h;
        gy_quo[0] <= '0;
        br_rem[0] <= w_bar_num;
        br_div[0] <= w_bw;
        br_quo[0] <= '0;
        r_dx      <= w_dx;
        r_dy      <= w_dy;
        mr[0]     <= MR_W'(w_min);
    end

    for (genvar k = 1; k <= NS; k++) begin : g_lane
        if (k <= GQ_W) begin : g_gcell
            tpg_div_cell #(.NW(GN_W), .DW(WW), .QW(GQ_W), .BIT(GQ_W - k)) u_gx (
                .i_clk (i_clk),
                .i_rem (gx_rem[k-1]), .i_div (gx_div[k-1]), .i_quo (gx_quo[k-1]),
                .o_rem (gx_rem[k]),   .o_div (gx_div[k]),   .o_quo (gx_quo[k])
            );
            tpg_div_cell #(.NW(GN_W), .DW(HW), .QW(GQ_W), .BIT(GQ_W - k)) u_gy (
                .i_clk (i_clk),
                .i_rem (gy_rem[k-1]), .i_div (gy_div[k-1]), .i_quo (gy_quo[k-1]),
                .o_rem (gy_rem[k]),   .o_div (gy_div[k]),   .o_quo (gy_quo[k])
            );
        end else begin : g_gfwd
            always_ff @(posedge i_clk) begin
                gx_rem[k] <= gx_rem[k-1];
                gx_div[k] <= gx_div[k-1];
                gx_quo[k] <= gx_quo[k-1];
                gy_rem[k] <= gy_rem[k-1];
                gy_div[k] <= gy_div[k-1];
                gy_quo[k] <= gy_quo[k-1];
            end
        end

        if (k <= BAR_Q_W) begin : g_bcell
            tpg_div_cell #(.NW(BAR_N_W), .DW(BW_W), .QW(BAR_Q_W), .BIT(BAR_Q_W - k)) u_bar (
                .i_clk (i_clk),
                .i_rem (br_rem[k-1]), .i_div (br_div[k-1]), .i_quo (br_quo[k-1]),
                .o_rem (br_rem[k]),   .o_div (br_div[k]),   .o_quo (br_quo[k])
            );
        end else begin : g_bfwd
            always_ff @(posedge i_clk) begin
                br_rem[k] <= br_rem[k-1];
                br_div[k] <= br_div[k-1];
                br_quo[k] <= br_quo[k-1];
            end
        end

        // max radius rides along until the radial divider picks it up
        if (k < RAD_INIT) begin : g_mr
            always_ff @(posedge i_clk) begin
                mr[k] <= mr[k-1];
            end
        end

        if (k == 1) begin : g_square
            always_ff @(posedge i_clk) begin
                sq_rem[k] <= (SQ_W'(r_dx) * SQ_W'(r_dx)) + (SQ_W'(r_dy) * SQ_W'(r_dy));
                sq_rt[k]  <= '0;
            end
        end else if (k < RAD_INIT) begin : g_root
            tpg_sqrt_cell #(.NW(SQ_W), .RW(ROOT_W), .BIT(RAD_INIT - 1 - k)) u_sqrt (
                .i_clk  (i_clk),
                .i_rem  (sq_rem[k-1]), .i_root (sq_rt[k-1]),
                .o_rem  (sq_rem[k]),   .o_root (sq_rt[k])
            );
        end else if (k == RAD_INIT) begin : g_rinit
            always_ff @(posedge i_clk) begin
                rd_rem[k] <= (RAD_N_W'(sq_rt[k-1]) << 7) - RAD_N_W'(sq_rt[k-1]);
                rd_div[k] <= mr[k-1];
                rd_quo[k] <= '0;
            end
        end else begin : g_rcell
            tpg_div_cell #(.NW(RAD_N_W), .DW(MR_W), .QW(RAD_Q_W), .BIT(NS - k)) u_rad (
                .i_clk (i_clk),
                .i_rem (rd_rem[k-1]), .i_div (rd_div[k-1]), .i_quo (rd_quo[k-1]),
                .o_rem (rd_rem[k]),   .o_div (rd_div[k]),   .o_quo (rd_quo[k])
            );
        end
    end

    // ---------------- result select and output register ----------------
    t_side               w_last;
    logic [GQ_W:0]       w_gsum;
    logic [SAMPLE_W-1:0] w_off;
    logic [SAMPLE_W-1:0] n_sample;
    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_outside;

    always_comb begin
        w_last = r_side[NS];
        w_gsum = {1'b0, gx_quo[NS]} + {1'b0, gy_quo[NS]};
        w_off  = rd_quo[NS][SAMPLE_W-1:0];
        if (w_last.outside) begin
            n_sample = '0;
        end else begin
            case (w_last.mode)
                MODE_BARS: n_sample = w_last.bar_ok ? bar_colour(br_quo[NS], w_last.plane)
                                                    : '0;
                MODE_GRAD: begin
                    if (w_last.plane == PLANE_Y)  n_sample = w_gsum[GQ_W:1];
                    else if (w_last.zero_rad)     n_sample = SAMPLE_W'(128);
                    else if (w_last.plane == PLANE_U) n_sample = SAMPLE_W'(128) + w_off;
                    else                          n_sample = SAMPLE_W'(128) - w_off;
                end
                default:   n_sample = w_last.simple;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else          r_out_vld <= r_vld[NS];
        r_sample  <= n_sample;
        r_outside <= w_last.outside;
    end

    assign o_valid   = r_out_vld;
    assign o_sample  = r_sample;
    assign o_outside = r_outside;
endmodule

@@ rtl/tpg_checker.sv @@
`timescale 1ns / 1ps
module tpg_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [tpg_pkg::APB_AW-1:0]    paddr,
    input logic [tpg_pkg::APB_DW-1:0]    pwdata,
    input logic [tpg_pkg::APB_DW-1:0]    prdata,
    input logic                          pready,
    input logic                          start,
    input logic                          busy,
    input logic [tpg_pkg::PLANE_W-1:0]   i_plane,
    input logic [tpg_pkg::COORD_W-1:0]   i_col,
    input logic [tpg_pkg::COORD_W-1:0]   i_row,
    input logic                          o_valid,
    input logic [tpg_pkg::SAMPLE_W-1:0]  o_sample,
    input logic                          o_outside
);
    import tpg_pkg::*;

    // every accepted beat gives its result after the fixed chain latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##PIPE_LAT o_valid)
        else $error("accepted beat gave no result");

    // no result without a beat accepted at the matching edge
    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result without accepted beat");

    // the unused plane code always reports outside
    a_plane_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_plane == PLANE_NONE) |-> ##PIPE_LAT (o_valid && o_outside))
        else $error("plane code three not flagged outside");

    // outside samples read zero
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outside |-> o_sample == '0)
        else $error("outside sample not zero");
endmodule

bind yuv420_test_pattern_generator tpg_checker u_tpg_checker (.*);
